>>> design/heap_kth_largest_select_defines.svh
// Assertion helpers used by the selection module.
`ifndef HEAP_KTH_LARGEST_SELECT_DEFINES_SVH
`define HEAP_KTH_LARGEST_SELECT_DEFINES_SVH

// Same-cycle check: when ante holds, cons must hold.
`define HKS_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle check: when ante holds, cons must hold in the next cycle.
`define HKS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/hks_pkg.sv
`timescale 1ns / 1ps

package hks_pkg;

   // Storage geometry.
   localparam int DEPTH   = 1024;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int CHILD_W = ADDR_W + 2;

   // Field widths.
   localparam int VAL_W = 32;
   localparam int K_W   = 11;

   // Rank register value after reset.
   localparam logic [K_W-1:0] K_RESET = K_W'(5);

   // One input item.
   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic                    is_last;
   } hks_req_type;

   // One result item.
   typedef struct packed {
      logic signed [VAL_W-1:0] kth_value;
      logic                    error;
   } hks_rsp_type;

endpackage

>>> design/hks_ram.sv
`timescale 1ns / 1ps

module hks_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 1024,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> design/heap_kth_largest_select.sv
`timescale 1ns / 1ps
`include "heap_kth_largest_select_defines.svh"

// K-th largest selection over a batch, using a binary max-heap in one RAM.
// Input: an item (value, is_last) transfers when start is high and busy is
// low. Items are written to the heap RAM one per cycle; busy stays low
// while a batch loads. The item with is_last set starts selection.
// Output: one result per batch, shown on rsp_item for exactly one cycle
// with rsp_valid high; the receiver cannot stall it.
// If the batch overflowed the store, or the rank exceeds the batch size,
// or the rank is zero, the result appears in the cycle after the last item.
// Otherwise busy is high while the heap is built by sift-down and k-1
// maxima are removed. Each sift reads and captures the moving value, then
// per tree level it descends does a left read, a right read, and a compare
// and write; it then stops and places the value. Reads are serialized, as
// the RAM has a single read port. The root is read in ST_ROOT_RD and
// captured in ST_ROOT_OUT, and the result is registered as the block
// returns to idle, so busy drops in the same cycle that the result appears.
// The rank register transfers on csr_valid and csr_ready; csr_ready is high
// while the block is idle. Reset clears the element count, the overflow
// mark and the result strobe and sets the rank to 5; the RAM is not
// cleared, as only entries of the current batch are ever read.
module heap_kth_largest_select (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  hks_pkg::hks_req_type req_item,
   output logic                rsp_valid,
   output hks_pkg::hks_rsp_type rsp_item,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [10:0]         csr_data
);
   import hks_pkg::*;

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_SETUP    = 11'b000_0000_0010,
      ST_BUILD_RD = 11'b000_0000_0100,
      ST_EXT_RD   = 11'b000_0000_1000,
      ST_GET_V    = 11'b000_0001_0000,
      ST_DESC     = 11'b000_0010_0000,
      ST_RD_R     = 11'b000_0100_0000,
      ST_CMP      = 11'b000_1000_0000,
      ST_PLACE    = 11'b001_0000_0000,
      ST_ROOT_RD  = 11'b010_0000_0000,
      ST_ROOT_OUT = 11'b100_0000_0000
   } state_type;

   // Control registers.
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic [K_W-1:0]    k_rank_ff, k_rank_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              build_ff, build_in;
   logic [K_W-1:0]    rem_ff, rem_in;

   // Datapath registers.
   logic [CNT_W-1:0]        size_ff, size_in;
   logic [ADDR_W-1:0]       node_ff, node_in;
   logic [ADDR_W-1:0]       build_idx_ff, build_idx_in;
   logic signed [VAL_W-1:0] v_ff, v_in;
   logic signed [VAL_W-1:0] best_ff, best_in;
   logic                    took_l_ff, took_l_in;
   logic signed [VAL_W-1:0] kth_ff, kth_in;
   logic                    err_ff, err_in;

   // RAM port signals.
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [VAL_W-1:0]  wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [VAL_W-1:0]  rd_data;
   logic signed [VAL_W-1:0] rd_val;

   // Derived indexes and flags.
   logic               in_xfer;
   logic               full;
   logic [CNT_W-1:0]   count_next;
   logic               ovf_next;
   logic [CHILD_W-1:0] left_idx, right_idx, size_ext;
   logic               left_ok, right_ok;
   logic [CNT_W-1:0]   last_idx;
   logic [CNT_W-1:0]   half, half_m1;

   hks_ram #(
      .WIDTH(VAL_W),
      .DEPTH(DEPTH)
   ) u_heap_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_val = signed'(rd_data);

   // Handshake outputs.
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign in_xfer   = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item.kth_value = kth_ff;
   assign rsp_item.error     = err_ff;

   // Load-side count and overflow.
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign count_next = full ? count_ff : count_ff + CNT_W'(1);
   assign ovf_next   = ovf_ff || full;

   // Heap index arithmetic.
   assign left_idx  = {1'b0, node_ff, 1'b1};
   assign right_idx = left_idx + CHILD_W'(1);
   assign size_ext  = CHILD_W'(size_ff);
   assign left_ok   = (left_idx < size_ext);
   assign right_ok  = (right_idx < size_ext);
   assign last_idx  = size_ff - CNT_W'(1);
   assign half      = size_ff >> 1;
   assign half_m1   = half - CNT_W'(1);

   // Sequencer and datapath next-state logic.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      k_rank_in    = k_rank_ff;
      rsp_valid_in = 1'b0;
      build_in     = build_ff;
      rem_in       = rem_ff;
      size_in      = size_ff;
      node_in      = node_ff;
      build_idx_in = build_idx_ff;
      v_in         = v_ff;
      best_in      = best_ff;
      took_l_in    = took_l_ff;
      kth_in       = kth_ff;
      err_in       = err_ff;
      wr_en        = 1'b0;
      wr_addr      = node_ff;
      wr_data      = v_ff;
      rd_en        = 1'b0;
      rd_addr      = node_ff;

      // Rank register transfer.
      if (csr_valid && csr_ready) begin
         k_rank_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (in_xfer) begin
               // Store the element while room remains.
               if (!full) begin
                  wr_en   = 1'b1;
                  wr_addr = count_ff[ADDR_W-1:0];
                  wr_data = req_item.value;
               end
               if (req_item.is_last) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  kth_in   = '0;
                  if (ovf_next) begin
                     rsp_valid_in = 1'b1;
                     err_in       = 1'b1;
                  end else if (k_rank_ff == '0) begin
                     rsp_valid_in = 1'b1;
                     err_in       = 1'b0;
                  end else if (32'(k_rank_ff) > 32'(count_next)) begin
                     rsp_valid_in = 1'b1;
                     err_in       = 1'b1;
                  end else begin
                     size_in  = count_next;
                     rem_in   = k_rank_ff;
                     state_in = ST_SETUP;
                  end
               end else begin
                  count_in = count_next;
                  ovf_in   = ovf_next;
               end
            end
         end

         ST_SETUP: begin
            // Build from the last internal node, or go straight to removal or the root read.
            if (half != '0) begin
               build_in     = 1'b1;
               build_idx_in = half_m1[ADDR_W-1:0];
               state_in     = ST_BUILD_RD;
            end else if (rem_ff == K_W'(1)) begin
               state_in = ST_ROOT_RD;
            end else begin
               rem_in   = rem_ff - K_W'(1);
               state_in = ST_EXT_RD;
            end
         end

         ST_BUILD_RD: begin
            rd_en    = 1'b1;
            rd_addr  = build_idx_ff;
            node_in  = build_idx_ff;
            state_in = ST_GET_V;
         end

         ST_EXT_RD: begin
            // The last leaf moves to the root; the old root is discarded.
            rd_en    = 1'b1;
            rd_addr  = last_idx[ADDR_W-1:0];
            size_in  = last_idx;
            node_in  = '0;
            state_in = ST_GET_V;
         end

         ST_GET_V: begin
            v_in     = rd_val;
            state_in = ST_DESC;
         end

         ST_DESC: begin
            if (left_ok) begin
               rd_en    = 1'b1;
               rd_addr  = left_idx[ADDR_W-1:0];
               state_in = ST_RD_R;
            end else begin
               state_in = ST_PLACE;
            end
         end

         ST_RD_R: begin
            // Left child is on the read port; keep the larger of it and v.
            took_l_in = (rd_val > v_ff);
            best_in   = (rd_val > v_ff) ? rd_val : v_ff;
            if (right_ok) begin
               rd_en   = 1'b1;
               rd_addr = right_idx[ADDR_W-1:0];
            end
            state_in = ST_CMP;
         end

         ST_CMP: begin
            // Move the larger child up into the hole, or stop here.
            if (right_ok && (rd_val > best_ff)) begin
               wr_en    = 1'b1;
               wr_data  = rd_data;
               node_in  = right_idx[ADDR_W-1:0];
               state_in = ST_DESC;
            end else if (took_l_ff) begin
               wr_en    = 1'b1;
               wr_data  = best_ff;
               node_in  = left_idx[ADDR_W-1:0];
               state_in = ST_DESC;
            end else begin
               state_in = ST_PLACE;
            end
         end

         ST_PLACE: begin
            // The sifted value settles in the hole.
            wr_en = 1'b1;
            if (build_ff && (build_idx_ff != '0)) begin
               build_idx_in = build_idx_ff - ADDR_W'(1);
               state_in     = ST_BUILD_RD;
            end else begin
               build_in = 1'b0;
               if (rem_ff == K_W'(1)) begin
                  state_in = ST_ROOT_RD;
               end else begin
                  rem_in   = rem_ff - K_W'(1);
                  state_in = ST_EXT_RD;
               end
            end
         end

         ST_ROOT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = ST_ROOT_OUT;
         end

         ST_ROOT_OUT: begin
            rsp_valid_in = 1'b1;
            kth_in       = rd_val;
            err_in       = 1'b0;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         k_rank_ff    <= K_RESET;
         rsp_valid_ff <= 1'b0;
         build_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         k_rank_ff    <= k_rank_in;
         rsp_valid_ff <= rsp_valid_in;
         build_ff     <= build_in;
      end
   end

   // Datapath registers without reset.
   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      size_ff      <= size_in;
      node_ff      <= node_in;
      build_idx_ff <= build_idx_in;
      v_ff         <= v_in;
      best_ff      <= best_in;
      took_l_ff    <= took_l_in;
      kth_ff       <= kth_in;
      err_ff       <= err_in;
   end

   // The sequencer never reads an entry in the cycle it writes it.
   `HKS_ASSERT_IMPL(a_no_rw_same_entry, wr_en && rd_en, wr_addr != rd_addr,
      "heap RAM read and write hit the same entry")

   // An error result always carries a zero value.
   `HKS_ASSERT_IMPL(a_error_zero_value, rsp_valid && rsp_item.error,
      rsp_item.kth_value == '0, "error result with nonzero value")

   // The removal count stays positive during selection.
   `HKS_ASSERT_IMPL(a_rem_positive, busy && (state_ff != ST_SETUP),
      rem_ff != '0, "removal count reached zero during selection")

   // Loading an element that is not last keeps the block ready.
   `HKS_ASSERT_NEXT(a_load_stays_idle, in_xfer && !req_item.is_last, !busy,
      "block went busy on an element that was not last")

endmodule
